>>> design/btc_pkg.sv
// ----------------------------------------------------------------------------
// Block transposition cipher package
// Shared constants, block descriptor and bank release types, and the
// block length clamp used by the core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

  // Largest block the buffers can hold, and the widths that follow from it.
  localparam int MaxBlock = 16;
  localparam int IDX_W    = $clog2(MaxBlock);
  localparam int CNT_W    = IDX_W + 1;
  localparam int BYTE_W   = 8;
  localparam int KEY_W    = 4;
  localparam int KEYS_W   = 64;

  // Padding byte, ASCII 'X'.
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h58;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0] REG_KEY_WORD     = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

  // Configuration reset values.
  localparam logic [4:0]        RST_BLOCK_LENGTH = 5'd4;
  localparam logic [KEYS_W-1:0] RST_KEY_WORD     = 64'hFEDC_BA98_7654_3210;
  localparam logic              RST_DECRYPT_MODE = 1'b0;

  // One collected block waiting to be emitted.
  typedef struct packed {
    logic             bank;     // buffer bank that holds the bytes
    logic [CNT_W-1:0] count;    // bytes actually received
    logic [CNT_W-1:0] len;      // effective block length at flush time
    logic             msg_end;  // block was flushed by the message end
  } blk_desc_t;

  // Back end hands a bank back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Clamp a raw block length to the range 1..MaxBlock.
  function automatic logic [CNT_W-1:0] eff_len(input logic [4:0] raw);
    logic [CNT_W-1:0] len;
    len = CNT_W'(raw);
    if (raw == 5'd0) begin
      len = CNT_W'(1);
    end else if (raw > 5'(MaxBlock)) begin
      len = CNT_W'(MaxBlock);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> design/btc_front.sv
// ----------------------------------------------------------------------------
// Block transposition cipher front end
// Collects message bytes into one of two buffer banks and posts a block
// descriptor when the block is full or the message ends.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [btc_pkg::BYTE_W-1:0]           in_byte,
  input  wire logic                                 message_end,
  input  wire logic [btc_pkg::CNT_W-1:0]            cfg_len,
  output logic                                      push,
  output btc_pkg::blk_desc_t                        push_desc,
  input  wire btc_pkg::bank_rel_t                   rel,
  input  wire logic                                 rd_bank,
  input  wire logic [btc_pkg::IDX_W-1:0]            rd_idx,
  output logic [btc_pkg::BYTE_W-1:0]                rd_data
);
  import btc_pkg::*;

  logic [BYTE_W-1:0] banks [2][MaxBlock];
  logic [1:0]        busy;
  logic [1:0]        busy_next;
  logic              wr_bank;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_inc;
  logic              accept;
  logic              flush;

  assign in_ready = !busy[wr_bank];
  assign accept   = in_valid && in_ready;
  assign fill_inc = fill + CNT_W'(1);
  assign flush    = accept && ((fill_inc >= cfg_len) || message_end);

  assign push      = flush;
  assign push_desc = '{bank: wr_bank, count: fill_inc, len: cfg_len, msg_end: message_end};

  assign rd_data = banks[rd_bank][rd_idx];

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (flush) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  // The fill count never passes MaxBlock-1 before a write, so the low bits
  // address the bank directly.
  always_ff @(posedge clk) begin
    if (accept) begin
      banks[wr_bank][fill[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      wr_bank <= 1'b0;
      fill    <= '0;
    end else begin
      busy <= busy_next;
      if (flush) begin
        wr_bank <= !wr_bank;
        fill    <= '0;
      end else if (accept) begin
        fill <= fill_inc;
      end
    end
  end

  // A bank being handed back cannot be the one just filled.
  a_no_release_on_fill: assert property (@(posedge clk) disable iff (rst)
    (flush && rel.valid) |-> (rel.bank != wr_bank))
    else $error("front: bank released while it is being filled");

endmodule

`default_nettype wire

>>> design/btc_queue.sv
// ----------------------------------------------------------------------------
// Block transposition cipher descriptor queue
// Two-entry queue of block descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire btc_pkg::blk_desc_t push_desc,
  input  wire logic               pop,
  output logic                    head_valid,
  output btc_pkg::blk_desc_t      head
);
  import btc_pkg::*;

  blk_desc_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       full;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Two banks bound the outstanding blocks, so the queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue: pop while empty");

endmodule

`default_nettype wire

>>> design/btc_back.sv
// ----------------------------------------------------------------------------
// Block transposition cipher back end
// Walks the output positions of the head block, resolves each position to a
// source byte through the key, and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire btc_pkg::blk_desc_t            head,
  output logic                               pop,
  output btc_pkg::bank_rel_t                 rel,
  input  wire logic [btc_pkg::KEYS_W-1:0]    key_word,
  input  wire logic                          decrypt_mode,
  output logic                               rd_bank,
  output logic [btc_pkg::IDX_W-1:0]          rd_idx,
  input  wire logic [btc_pkg::BYTE_W-1:0]    rd_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [btc_pkg::BYTE_W-1:0]         out_byte,
  output logic                               run_last,
  output logic                               message_last
);
  import btc_pkg::*;

  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  src;
  logic              hit;
  logic              pad;
  logic              load;
  logic              last_pos;
  logic [KEY_W-1:0]  enc_key;
  logic [BYTE_W-1:0] byte_sel;

  assign enc_key = key_word[{pos, 2'b00} +: KEY_W];

  // Encrypt gathers: position pos takes byte key[pos]. Decrypt scatters:
  // position pos takes the byte of the highest entry that names it.
  always_comb begin
    hit = 1'b0;
    src = '0;
    if (!decrypt_mode) begin
      hit = (CNT_W'(enc_key) < head.len);
      src = IDX_W'(enc_key);
    end else begin
      for (int j = 0; j < MaxBlock; j++) begin
        if ((CNT_W'(j) < head.len) &&
            (key_word[j*KEY_W +: KEY_W] == KEY_W'(pos))) begin
          hit = 1'b1;
          src = IDX_W'(j);
        end
      end
    end
  end

  assign rd_bank  = head.bank;
  assign rd_idx   = src;
  assign pad      = !hit || (CNT_W'(src) >= head.count);
  assign byte_sel = pad ? PAD_BYTE : rd_data;

  assign load     = head_valid && (!out_valid || out_ready);
  assign last_pos = (CNT_W'(pos) == (head.len - CNT_W'(1)));
  assign pop      = load && last_pos;
  assign rel      = '{valid: pop, bank: head.bank};

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_sel;
      run_last     <= last_pos;
      message_last <= last_pos && head.msg_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last_pos ? '0 : pos + IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pos_in_block: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (CNT_W'(pos) < head.len))
    else $error("back: output position beyond block length");

endmodule

`default_nettype wire

>>> design/block_transposition_cipher_core.sv
// ----------------------------------------------------------------------------
// Block transposition cipher core
// Collects message bytes into blocks and emits each block reordered by a
// 16-entry key permutation, gathering in encrypt mode and scattering in
// decrypt mode, with short final blocks padded by 'X'.
// ----------------------------------------------------------------------------
// Flow: the byte that completes a block posts its descriptor to the queue, and
//   the back end then loads the block's first byte into the output register once it is free.
// Throughput: one byte per cycle sustained while out_ready stays high; input
//   stalls only while both buffer banks are still held.
// Reset: rst clears all control state and loads the register reset values;
//   the byte buffers are not cleared, and no clearing pass is needed.
`default_nettype none

module block_transposition_cipher_core (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input requests.
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         message_end,
  // Output requests.
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              run_last,
  output logic              message_last,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import btc_pkg::*;

  // Configuration registers. They change only while the core is idle, as the user must ensure;
  // the core does not enforce it. The front and back ends read them live.
  logic [4:0]        block_length;
  logic [KEYS_W-1:0] key_word;
  logic              decrypt_mode;
  logic              cfg_write;
  logic [1:0]        reg_idx;
  logic [CNT_W-1:0]  cfg_len;

  // Front to queue to back.
  logic              push;
  blk_desc_t         push_desc;
  logic              pop;
  logic              head_valid;
  blk_desc_t         head;
  bank_rel_t         rel;
  logic              rd_bank;
  logic [IDX_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] rd_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_len   = eff_len(block_length);

  // Registers sit on 8-byte boundaries because the key register is 64 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= RST_BLOCK_LENGTH;
      key_word     <= RST_KEY_WORD;
      decrypt_mode <= RST_DECRYPT_MODE;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_BLOCK_LENGTH: block_length <= pwdata[4:0];
        REG_KEY_WORD:     key_word     <= pwdata;
        REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_LENGTH: prdata = {59'd0, block_length};
      REG_KEY_WORD:     prdata = key_word;
      REG_DECRYPT_MODE: prdata = {63'd0, decrypt_mode};
      default:          prdata = '0;
    endcase
  end

  // The front end fills one bank while the back end drains the other; block
  // descriptors pass through a two-entry queue so either side can stall.
  btc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .message_end (message_end),
    .cfg_len     (cfg_len),
    .push        (push),
    .push_desc   (push_desc),
    .rel         (rel),
    .rd_bank     (rd_bank),
    .rd_idx      (rd_idx),
    .rd_data     (rd_data)
  );

  btc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  btc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .rel          (rel),
    .key_word     (key_word),
    .decrypt_mode (decrypt_mode),
    .rd_bank      (rd_bank),
    .rd_idx       (rd_idx),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .message_last (message_last)
  );

  // The end of a message always closes a block.
  a_msg_last_ends_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_last) |-> run_last)
    else $error("core: message end without block end");

endmodule

`default_nettype wire
